// ===== rtl/sfscp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfscp_pkg
// Shared constants for the sensor frame sync and checksum parser.
// ----------------------------------------------------------------------------
package sfscp_pkg;

    localparam int FRAME_BYTES_DEF = 32;
    localparam int MAX_WORDS       = 13;

    localparam logic [7:0] HDR_BYTE0 = 8'h42;
    localparam logic [7:0] HDR_BYTE1 = 8'h4d;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_HDR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;
    localparam logic [1:0] ST_BAD_SUM = 2'd3;

    // Link synchronization phases
    localparam logic [1:0] PH_HUNT0   = 2'd0;
    localparam logic [1:0] PH_HUNT1   = 2'd1;
    localparam logic [1:0] PH_COLLECT = 2'd2;

endpackage : sfscp_pkg
`default_nettype wire

// ===== rtl/sensor_frame_sync_checksum_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_frame_sync_checksum_parser_core
// Serial frame parser: header hunt, frame capture, length and sum check.
//
// Input stream (s_axis): one received byte per transaction. The block hunts
// for 0x42 0x4d, then stores frame bytes 2..FRAME_BYTES-1 while adding bytes
// 0..FRAME_BYTES-3 into a 16-bit running sum with a single adder.
// Output stream (m_axis): on the final frame byte a bad frame gives one error
// transaction (index 0, value 0, status, tlast). A good frame gives one
// transaction per big-endian data word from byte 4 on, tlast on the last.
// Bytes that do not close a frame are taken back to back. After the closing
// byte, an error result is valid the next cycle; each data word passes
// through S_HI (high read), S_LO (low read), S_LOAD (output load) and S_OUT
// (output handshake), since the frame store has a single read port.
// s_axis_tready is low from the closing byte until the last result is taken;
// a stalled receiver simply holds the output register and the sequencer.
// Reset (synchronous, active low) returns to the header hunt and drops any
// pending result. The frame store needs no clearing.
// ----------------------------------------------------------------------------
module sensor_frame_sync_checksum_parser_core
    import sfscp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [3:0] word_index, [19:4] word_value,
                                             // [21:20] status, [23:22] zero
    output logic             m_axis_tlast    // last
);

    localparam int AW     = $clog2(FRAME_BYTES);
    localparam int NW_RAW = (FRAME_BYTES - 6) / 2;
    localparam int NW     = (NW_RAW > MAX_WORDS) ? MAX_WORDS : NW_RAW;

    localparam logic [AW-1:0] LEN_IDX   = AW'(3);
    localparam logic [AW-1:0] CKH_IDX   = AW'(FRAME_BYTES - 2);
    localparam logic [AW-1:0] LAST_IDX  = AW'(FRAME_BYTES - 1);
    localparam logic [7:0]    LEN_VALUE = 8'(FRAME_BYTES - 4);
    localparam logic [3:0]    LAST_WORD = 4'(NW - 1);

    // Sequencer states
    localparam logic [2:0] S_RX   = 3'd0;
    localparam logic [2:0] S_HI   = 3'd1;
    localparam logic [2:0] S_LO   = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [AW-1:0] r_count, n_count;
    logic [15:0]   r_sum,   n_sum;
    logic [7:0]    r_len,   n_len;
    logic [7:0]    r_ckh,   n_ckh;
    logic [7:0]    r_hi,    n_hi;
    logic [3:0]    r_word,  n_word;
    logic [3:0]    r_oidx,  n_oidx;
    logic [15:0]   r_oval,  n_oval;
    logic [1:0]    r_ost,   n_ost;
    logic          r_olast, n_olast;

    logic          w_in_acc;
    logic          w_out_acc;
    logic          w_we;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;
    logic [15:0]   w_sum_add;
    logic [1:0]    w_status;

    assign s_axis_tready = (r_state == S_RX);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {2'b00, r_ost, r_oval, r_oidx};
    assign m_axis_tlast  = r_olast;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_we      = w_in_acc && (r_phase == PH_COLLECT);

    // Single adder: running sum while collecting
    assign w_sum_add = r_sum + {8'h00, s_axis_tdata};

    // Header bytes are placed by the hunt itself, so only length and sum can fail
    always_comb begin
        priority if (r_len != LEN_VALUE) begin
            w_status = ST_BAD_LEN;
        end else if ({r_ckh, s_axis_tdata} != r_sum) begin
            w_status = ST_BAD_SUM;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        w_raddr = AW'({r_word, 1'b0}) + AW'(4);
        if (r_state == S_LO) begin
            w_raddr = AW'({r_word, 1'b1}) + AW'(4);
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_count = r_count;
        n_sum   = r_sum;
        n_len   = r_len;
        n_ckh   = r_ckh;
        n_hi    = r_hi;
        n_word  = r_word;
        n_oidx  = r_oidx;
        n_oval  = r_oval;
        n_ost   = r_ost;
        n_olast = r_olast;

        unique case (r_state)
            S_RX: begin
                if (w_in_acc) begin
                    unique case (r_phase)
                        PH_HUNT1: begin
                            if (s_axis_tdata == HDR_BYTE1) begin
                                n_phase = PH_COLLECT;
                                n_count = AW'(2);
                                n_sum   = 16'(HDR_BYTE0) + 16'(HDR_BYTE1);
                            end else begin
                                n_phase = PH_HUNT0;
                            end
                        end
                        PH_COLLECT: begin
                            if (r_count < CKH_IDX) begin
                                n_sum = w_sum_add;
                            end
                            if (r_count == LEN_IDX) begin
                                n_len = s_axis_tdata;
                            end
                            if (r_count == CKH_IDX) begin
                                n_ckh = s_axis_tdata;
                            end
                            n_count = r_count + AW'(1);
                            if (r_count == LAST_IDX) begin
                                // Frame closed: rearm hunting and start results
                                n_phase = PH_HUNT0;
                                n_count = '0;
                                n_word  = 4'd0;
                                if (w_status != ST_OK) begin
                                    n_oidx  = 4'd0;
                                    n_oval  = 16'h0000;
                                    n_ost   = w_status;
                                    n_olast = 1'b1;
                                    n_state = S_OUT;
                                end else begin
                                    n_state = S_HI;
                                end
                            end
                        end
                        default: begin
                            n_phase = (s_axis_tdata == HDR_BYTE0) ? PH_HUNT1 : PH_HUNT0;
                        end
                    endcase
                end
            end
            S_HI: begin
                n_state = S_LO;
            end
            S_LO: begin
                n_hi    = w_rdata;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_oidx  = r_word;
                n_oval  = {r_hi, w_rdata};
                n_ost   = ST_OK;
                n_olast = (r_word == LAST_WORD);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_acc) begin
                    if (r_olast) begin
                        n_state = S_RX;
                    end else begin
                        n_word  = r_word + 4'd1;
                        n_state = S_HI;
                    end
                end
            end
            default: begin
                n_state = S_RX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
            r_phase <= PH_HUNT0;
            r_count <= '0;
            r_sum   <= 16'h0000;
            r_word  <= 4'd0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_word  <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_ckh   <= n_ckh;
        r_hi    <= n_hi;
        r_oidx  <= n_oidx;
        r_oval  <= n_oval;
        r_ost   <= n_ost;
        r_olast <= n_olast;
    end

    sfscp_store #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count),
        .i_wdata (s_axis_tdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // No byte is taken while a result waits
    a_no_rx_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while a result is pending");

    // An error result always closes its frame
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[21:20] != ST_OK)) |-> m_axis_tlast)
        else $error("error result without tlast");

    // After the last result the hunt resumes at once
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("input not rearmed after the last result");

    // Words of a good frame come out in order
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (r_word == $past(r_word) + 4'd1))
        else $error("word index did not advance");

endmodule : sensor_frame_sync_checksum_parser_core
`default_nettype wire

// ===== rtl/sfscp_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfscp_store
// Frame byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sfscp_store
    import sfscp_pkg::*;
#(
    parameter int DEPTH = FRAME_BYTES_DEF,
    parameter int AW    = $clog2(FRAME_BYTES_DEF)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : sfscp_store
`default_nettype wire
